// File: hw/rtl/gbps_pkg.sv
// ----------------------------------------------------------------------------
// gbps_pkg
// Shared types and constants of the gear button pulse sequencer: field
// widths, function and frame kind codes, button encoding, register indexes
// and the result record.
// ----------------------------------------------------------------------------
package gbps_pkg;

  // Field widths
  localparam int FuncW  = 2;
  localparam int TimeW  = 32;
  localparam int GearW  = 3;
  localparam int FreeW  = 2;
  localparam int KindW  = 2;
  localparam int CodeW  = 8;
  localparam int MsW    = 16;
  localparam int BytesW = 64;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Input function codes
  localparam logic [FuncW-1:0] FUNC_SERVICE = 2'd0;
  localparam logic [FuncW-1:0] FUNC_REQUEST = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CANCEL  = 2'd2;

  // Frame kinds
  localparam logic [KindW-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KindW-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KindW-1:0] KIND_BEAT    = 2'd2;

  // Button encoding: gears 0..3, plus "no button"
  localparam logic [GearW-1:0] BTN_PARK    = 3'd0;
  localparam logic [GearW-1:0] BTN_REVERSE = 3'd1;
  localparam logic [GearW-1:0] BTN_NEUTRAL = 3'd2;
  localparam logic [GearW-1:0] BTN_DRIVE   = 3'd3;
  localparam logic [GearW-1:0] BTN_NONE    = 3'd4;

  // Queue space saturates at two frames
  localparam logic [FreeW-1:0] FREE_MAX = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_CODE_NONE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CODE_PARK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CODE_REVERSE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CODE_NEUTRAL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CODE_DRIVE   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HOLD_MS      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BEAT_PERIOD  = 3'd6;

  // Register reset values
  localparam logic [CodeW-1:0] RST_CODE_NONE    = 8'd0;
  localparam logic [CodeW-1:0] RST_CODE_PARK    = 8'd1;
  localparam logic [CodeW-1:0] RST_CODE_REVERSE = 8'd2;
  localparam logic [CodeW-1:0] RST_CODE_NEUTRAL = 8'd3;
  localparam logic [CodeW-1:0] RST_CODE_DRIVE   = 8'd4;
  localparam logic [MsW-1:0]   RST_HOLD_MS      = 16'd200;
  localparam logic [MsW-1:0]   RST_BEAT_PERIOD  = 16'd100;

  // Fixed frame bytes
  localparam logic [7:0] BYTE_HDR0    = 8'h04;
  localparam logic [7:0] BYTE_HDR1    = 8'h1B;
  localparam logic [7:0] BYTE_BEAT_ID = 8'hF9;
  localparam logic [7:0] BYTE_EVT_ID  = 8'h01;
  localparam logic [7:0] BYTE_TAG     = 8'h21;
  localparam logic [7:0] BYTE_FILL    = 8'hFF;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  // Pulse phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESS,
    PH_HELD,
    PH_RELEASE
  } phase_t;

  // One result beat
  typedef struct packed {
    logic              frame_valid;
    logic [BytesW-1:0] frame_bytes;
    logic [KindW-1:0]  frame_kind;
    logic              accepted;
    logic              request_ok;
    logic              healthy;
    logic              last;
  } res_t;

endpackage

// File: hw/rtl/gbps_in_if.sv
// ----------------------------------------------------------------------------
// gbps_in_if
// Input channel: one function beat (service, request or cancel).
// ----------------------------------------------------------------------------
interface gbps_in_if
  import gbps_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [TimeW-1:0] now_ms;
  logic [GearW-1:0] gear;
  logic [FreeW-1:0] tx_free;

  modport source (output valid, func, now_ms, gear, tx_free, input ready);
  modport sink   (input valid, func, now_ms, gear, tx_free, output ready);
endinterface

// File: hw/rtl/gbps_out_if.sv
// ----------------------------------------------------------------------------
// gbps_out_if
// Result channel: one frame attempt or status beat.
// ----------------------------------------------------------------------------
interface gbps_out_if
  import gbps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              frame_valid;
  logic [BytesW-1:0] frame_bytes;
  logic [KindW-1:0]  frame_kind;
  logic              accepted;
  logic              request_ok;
  logic              healthy;
  logic              last;

  modport source (output valid, frame_valid, frame_bytes, frame_kind, accepted,
                  request_ok, healthy, last, input ready);
  modport sink   (input valid, frame_valid, frame_bytes, frame_kind, accepted,
                  request_ok, healthy, last, output ready);
endinterface

// File: hw/rtl/gbps_cfg_if.sv
// ----------------------------------------------------------------------------
// gbps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gbps_cfg_if
  import gbps_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/gear_button_pulse_sequencer_core.sv
// ----------------------------------------------------------------------------
// gear_button_pulse_sequencer_core
// Turns gear requests into press/release keypad frames with periodic
// heartbeats, and reports each frame attempt on the result channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one beat per call: service at now_ms, gear request or cancel.
//            tx_free says how many frames the transmit queue takes during a
//            service (3 counts as 2).
//   out_ch - result beats. A service that attempts frames gives one beat per
//            frame (press or release first, heartbeat second); every other
//            beat gives a single status beat. last marks the final beat of
//            an input beat.
//   cfg_ch - register writes, always ready; index 0..6, higher ignored.
//            Write only while the block is idle.
// Timing: the result is registered and shows in the cycle after the input
//   beat is taken. An input beat is taken every cycle while the receiver is
//   ready and no second frame is pending; a service that attempts two frames
//   keeps its heartbeat beat in the pending slot, so the next input beat waits
//   for both beats. The result register and pending slot set this rate.
// Reset: synchronous, rst_n low. Registers return to their defaults, phase
//   idle, heartbeat due at once, health set. A stalled receiver holds the
//   current result; input is taken again as soon as that result is taken
//   and no second frame is pending.
// ----------------------------------------------------------------------------
module gear_button_pulse_sequencer_core
  import gbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  gbps_in_if.sink           in_ch,
  gbps_out_if.source        out_ch,
  gbps_cfg_if.sink          cfg_ch
);

  // Configuration registers
  logic [CodeW-1:0] code_none_r, code_park_r, code_reverse_r;
  logic [CodeW-1:0] code_neutral_r, code_drive_r;
  logic [MsW-1:0]   hold_ms_r, beat_period_r;

  // Sequencer state
  phase_t           phase_r, phase_nxt;
  logic [GearW-1:0] pulse_btn_r, pulse_btn_nxt;
  logic [GearW-1:0] shown_btn_r, shown_btn_nxt;
  logic [GearW-1:0] wait_btn_r, wait_btn_nxt;
  logic             beat_shown_r, beat_shown_nxt;
  logic [TimeW-1:0] press_time_r, press_time_nxt;
  logic [TimeW-1:0] deadline_r, deadline_nxt;
  logic [7:0]       beat_count_r, beat_count_nxt;
  logic             health_r, health_nxt;

  // Result stage
  logic out_valid_r, pend_r;
  res_t out_res_r, pend_res_r;
  res_t res0, res1;
  logic two_res;

  logic in_fire, out_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || (out_ch.ready && !pend_r);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;

  // Button to keypad code
  function automatic logic [CodeW-1:0] code_of(input logic [GearW-1:0] btn,
      input logic [CodeW-1:0] c_none, input logic [CodeW-1:0] c_park,
      input logic [CodeW-1:0] c_rev, input logic [CodeW-1:0] c_neu,
      input logic [CodeW-1:0] c_drv);
    logic [CodeW-1:0] c;
    case (btn)
      BTN_PARK:    c = c_park;
      BTN_REVERSE: c = c_rev;
      BTN_NEUTRAL: c = c_neu;
      BTN_DRIVE:   c = c_drv;
      default:     c = c_none;
    endcase
    return c;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_none_r    <= RST_CODE_NONE;
      code_park_r    <= RST_CODE_PARK;
      code_reverse_r <= RST_CODE_REVERSE;
      code_neutral_r <= RST_CODE_NEUTRAL;
      code_drive_r   <= RST_CODE_DRIVE;
      hold_ms_r      <= RST_HOLD_MS;
      beat_period_r  <= RST_BEAT_PERIOD;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CODE_NONE:    code_none_r    <= cfg_ch.data[CodeW-1:0];
        REG_CODE_PARK:    code_park_r    <= cfg_ch.data[CodeW-1:0];
        REG_CODE_REVERSE: code_reverse_r <= cfg_ch.data[CodeW-1:0];
        REG_CODE_NEUTRAL: code_neutral_r <= cfg_ch.data[CodeW-1:0];
        REG_CODE_DRIVE:   code_drive_r   <= cfg_ch.data[CodeW-1:0];
        REG_HOLD_MS:      hold_ms_r      <= cfg_ch.data[MsW-1:0];
        REG_BEAT_PERIOD:  beat_period_r  <= cfg_ch.data[MsW-1:0];
        default: ;
      endcase
    end
  end

  // Next state and results for the current input beat
  always_comb begin
    logic [FreeW-1:0] avail;
    logic [TimeW-1:0] elapsed, beat_diff, next_dl, next_diff;
    logic             evt_try, evt_rel, evt_acc, beat_due, beat_acc;
    logic             hold_done;
    logic [CodeW-1:0] evt_code, beat_code;
    logic [BytesW-1:0] evt_bytes, beat_bytes;
    res_t             evt_res, beat_res, null_res;

    phase_nxt      = phase_r;
    pulse_btn_nxt  = pulse_btn_r;
    shown_btn_nxt  = shown_btn_r;
    wait_btn_nxt   = wait_btn_r;
    beat_shown_nxt = beat_shown_r;
    press_time_nxt = press_time_r;
    deadline_nxt   = deadline_r;
    beat_count_nxt = beat_count_r;
    health_nxt     = health_r;

    avail = (in_ch.tx_free > FREE_MAX) ? FREE_MAX : in_ch.tx_free;

    null_res   = '0;
    evt_res    = '0;
    beat_res   = '0;
    res0       = '0;
    res1       = '0;
    two_res    = 1'b0;
    beat_code  = '0;
    beat_bytes = '0;

    // Press / release step
    elapsed   = in_ch.now_ms - press_time_r;
    hold_done = elapsed >= {{(TimeW-MsW){1'b0}}, hold_ms_r};
    evt_rel   = (phase_r == PH_RELEASE) ||
                (phase_r == PH_HELD && beat_shown_r && hold_done);
    evt_try   = (phase_r == PH_PRESS) || evt_rel;
    evt_acc   = (avail != 2'd0);
    evt_code  = code_of(pulse_btn_r, code_none_r, code_park_r, code_reverse_r,
                        code_neutral_r, code_drive_r);
    evt_bytes = {BYTE_FILL, BYTE_FILL, BYTE_TAG, 7'd0, !evt_rel,
                 BYTE_EVT_ID, evt_code, BYTE_HDR1, BYTE_HDR0};

    // Heartbeat timing, wraparound compare
    beat_diff = in_ch.now_ms - deadline_r;
    beat_due  = !beat_diff[TimeW-1];
    next_dl   = deadline_r + {{(TimeW-MsW){1'b0}}, beat_period_r};
    next_diff = in_ch.now_ms - next_dl;
    if (!next_diff[TimeW-1]) begin
      next_dl = in_ch.now_ms + {{(TimeW-MsW){1'b0}}, beat_period_r};
    end
    beat_acc = evt_try ? (avail == FREE_MAX) : (avail != 2'd0);

    case (in_ch.func)
      FUNC_SERVICE: begin
        if (evt_try) begin
          if (!evt_rel) begin
            if (evt_acc) begin
              shown_btn_nxt  = pulse_btn_r;
              press_time_nxt = in_ch.now_ms;
              beat_shown_nxt = 1'b0;
              phase_nxt      = PH_HELD;
            end
          end else if (evt_acc) begin
            // Pulse done: start the queued button if there is one
            wait_btn_nxt   = BTN_NONE;
            shown_btn_nxt  = BTN_NONE;
            beat_shown_nxt = 1'b0;
            pulse_btn_nxt  = wait_btn_r;
            phase_nxt      = (wait_btn_r != BTN_NONE) ? PH_PRESS : PH_IDLE;
          end else begin
            phase_nxt = PH_RELEASE;
          end
        end

        // Heartbeat shows the button after the event step
        beat_code  = code_of(shown_btn_nxt, code_none_r, code_park_r,
                             code_reverse_r, code_neutral_r, code_drive_r);
        beat_bytes = {BYTE_TAG, BYTE_FILL, BYTE_ZERO, beat_code, beat_count_r,
                      BYTE_BEAT_ID, BYTE_HDR1, BYTE_HDR0};
        if (beat_due) begin
          deadline_nxt = next_dl;
          if (beat_acc) begin
            beat_count_nxt = beat_count_r + 8'd1;
            if (shown_btn_nxt != BTN_NONE) begin
              beat_shown_nxt = 1'b1;
            end
          end
        end

        if (evt_try || beat_due) begin
          health_nxt = (!evt_try || evt_acc) && (!beat_due || beat_acc);
        end

        evt_res.frame_valid = 1'b1;
        evt_res.frame_bytes = evt_bytes;
        evt_res.frame_kind  = evt_rel ? KIND_RELEASE : KIND_PRESS;
        evt_res.accepted    = evt_acc;
        beat_res.frame_valid = 1'b1;
        beat_res.frame_bytes = beat_bytes;
        beat_res.frame_kind  = KIND_BEAT;
        beat_res.accepted    = beat_acc;

        if (evt_try) begin
          res0    = evt_res;
          res1    = beat_res;
          two_res = beat_due;
        end else if (beat_due) begin
          res0 = beat_res;
        end else begin
          res0 = null_res;
        end
      end
      FUNC_REQUEST: begin
        if (in_ch.gear <= BTN_DRIVE) begin
          res0.request_ok = 1'b1;
          case (phase_r)
            PH_IDLE: begin
              pulse_btn_nxt  = in_ch.gear;
              shown_btn_nxt  = BTN_NONE;
              beat_shown_nxt = 1'b0;
              phase_nxt      = PH_PRESS;
            end
            PH_PRESS: pulse_btn_nxt = in_ch.gear;
            default:  wait_btn_nxt  = in_ch.gear;
          endcase
        end
      end
      FUNC_CANCEL: begin
        wait_btn_nxt = BTN_NONE;
        if (phase_r == PH_PRESS) begin
          pulse_btn_nxt  = BTN_NONE;
          shown_btn_nxt  = BTN_NONE;
          beat_shown_nxt = 1'b0;
          phase_nxt      = PH_IDLE;
        end
      end
      default: ;
    endcase

    res0.healthy = health_nxt;
    res1.healthy = health_nxt;
    res0.last    = !two_res;
    res1.last    = 1'b1;
  end

  // State register, advanced per accepted input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pulse_btn_r  <= BTN_NONE;
      shown_btn_r  <= BTN_NONE;
      wait_btn_r   <= BTN_NONE;
      beat_shown_r <= 1'b0;
      press_time_r <= '0;
      deadline_r   <= '0;
      beat_count_r <= '0;
      health_r     <= 1'b1;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      pulse_btn_r  <= pulse_btn_nxt;
      shown_btn_r  <= shown_btn_nxt;
      wait_btn_r   <= wait_btn_nxt;
      beat_shown_r <= beat_shown_nxt;
      press_time_r <= press_time_nxt;
      deadline_r   <= deadline_nxt;
      beat_count_r <= beat_count_nxt;
      health_r     <= health_nxt;
    end
  end

  // Result register with one pending slot for the heartbeat beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
      pend_r      <= two_res;
    end else if (out_fire) begin
      if (pend_r) begin
        pend_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r  <= res0;
      pend_res_r <= res1;
    end else if (out_fire && pend_r) begin
      out_res_r <= pend_res_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_valid = out_res_r.frame_valid;
  assign out_ch.frame_bytes = out_res_r.frame_bytes;
  assign out_ch.frame_kind  = out_res_r.frame_kind;
  assign out_ch.accepted    = out_res_r.accepted;
  assign out_ch.request_ok  = out_res_r.request_ok;
  assign out_ch.healthy     = out_res_r.healthy;
  assign out_ch.last        = out_res_r.last;

endmodule
